// ===== src/bsl_pkg.sv =====
// Shared types and constants of the 24-bit BMP stream loader.
`default_nettype none

package bsl_pkg;

  // Fixed field widths.
  localparam int OFF_W      = 22;
  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_DATA_W = 48;

  // Header layout: length and positions of the little-endian fields.
  localparam int HDR_LEN        = 54;
  localparam int HDR_CNT_W      = 6;
  localparam int HDR_WIDTH_POS  = 18;
  localparam int HDR_HEIGHT_POS = 22;
  localparam int HDR_BPP_POS    = 28;

  // Pixel format.
  localparam int BPP_24    = 24;
  localparam int PIX_BYTES = 3;

  // Result queue between the parser and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_PAD
  } phase_t;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_REJECT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] expected_width;
    logic [CFG_W-1:0] expected_height;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [OFF_W-1:0]  byte_offset;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] third_byte;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/bsl_front.sv =====
// Parser: collects the header, checks it and turns pixel bytes into write results.
`default_nettype none

module bsl_front
  import bsl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_accept,
  input  wire logic [BYTE_W-1:0] byte_value,
  input  wire logic              file_start,
  input  wire cfg_t              cfg,
  output logic                   push,
  output result_t                push_data
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int W3W = CW + 2;
  localparam int PW  = RW + W3W;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [HDR_CNT_W-1:0]   header_count;
  logic [15:0]            bit_count_field;
  logic [31:0]            width_field;
  logic [31:0]            height_field;
  logic [RW-1:0]          row_count;
  logic [CW-1:0]          column_count;
  logic [1:0]             byte_in_pixel;
  logic [1:0]             pad_count;
  logic [BYTE_W-1:0]      held_first;
  logic [BYTE_W-1:0]      held_second;
  logic [OFF_W-1:0]       row_base;
  logic [OFF_W-1:0]       pixel_offset;
  logic [W3W-1:0]         row_bytes;
  logic [OFF_W-1:0]       base_prod;

  logic [CW-1:0]          img_w;
  logic [RW-1:0]          img_h;
  logic [RW-1:0]          img_h_m1;
  logic [PW-1:0]          prod_full;
  logic [1:0]             pad;
  logic [1:0]             lane_w;
  logic [1:0]             lane_h;
  logic [1:0]             lane_b;
  logic                   col_last;
  logic                   row_last;
  logic                   hdr_end;
  logic                   hdr_bad;
  logic                   hdr_zero;
  logic                   pix_emit;
  logic                   go_pad;
  logic                   row_done;
  logic [OFF_W-1:0]       next_base;

  // Image dimensions as held in the header fields; taken as the image size only once the header passed.
  assign img_w    = width_field[CW-1:0];
  assign img_h    = height_field[RW-1:0];
  assign img_h_m1 = RW'(img_h - 1'b1);
  assign pad      = 2'(img_w);
  assign col_last = (CW'(column_count + 1'b1) == img_w);
  assign row_last = (RW'(row_count + 1'b1) == img_h);

  // Byte lane of the header field being collected.
  assign lane_w = 2'(header_count - HDR_CNT_W'(HDR_WIDTH_POS));
  assign lane_h = 2'(header_count - HDR_CNT_W'(HDR_HEIGHT_POS));
  assign lane_b = 2'(header_count - HDR_CNT_W'(HDR_BPP_POS));

  // Header check on its last byte.
  assign hdr_end  = (phase == PH_HEADER) && !file_start &&
                    (header_count == HDR_CNT_W'(HDR_LEN - 1));
  assign hdr_bad  = (bit_count_field != 16'(BPP_24)) ||
                    (width_field != 32'(cfg.expected_width)) ||
                    (height_field != 32'(cfg.expected_height)) ||
                    (width_field > 32'(MAX_WIDTH)) ||
                    (height_field > 32'(MAX_HEIGHT));
  assign hdr_zero = (width_field == 32'd0) || (height_field == 32'd0);

  // Pixel grouping and the end of a row.
  assign pix_emit = (phase == PH_PIXELS) && !file_start && (byte_in_pixel == 2'd2);
  assign go_pad   = pix_emit && col_last && (pad != 2'd0) && !row_last;
  assign row_done = (pix_emit && col_last && !go_pad) ||
                    ((phase == PH_PAD) && !file_start && (pad_count == 2'd1));

  // Row offset steps back by one row of bytes for the flipped order.
  assign next_base = row_base - OFF_W'(row_bytes);

  // Offset of the bottom row, formed while the rest of the header streams in.
  assign prod_full = PW'(img_h_m1) * PW'(row_bytes);

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    if (in_accept) begin
      if (file_start) begin
        phase_next = PH_HEADER;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            phase_next = PH_IDLE;
          end
          PH_HEADER: begin
            if (hdr_end) begin
              phase_next = (hdr_bad || hdr_zero) ? PH_IDLE : PH_PIXELS;
            end
          end
          PH_PIXELS: begin
            if (go_pad) begin
              phase_next = PH_PAD;
            end else if (row_done) begin
              phase_next = row_last ? PH_IDLE : PH_PIXELS;
            end
          end
          PH_PAD: begin
            if (row_done) begin
              phase_next = row_last ? PH_IDLE : PH_PIXELS;
            end
          end
        endcase
      end
    end
  end

  // Result towards the queue.
  always_comb begin
    push      = in_accept && ((hdr_end && hdr_bad) || pix_emit);
    push_data = '0;
    if (pix_emit) begin
      push_data.kind        = KIND_PIXEL;
      push_data.byte_offset = pixel_offset;
      push_data.first_byte  = held_first;
      push_data.second_byte = held_second;
      push_data.third_byte  = byte_value;
      push_data.last        = row_last && col_last;
    end else begin
      push_data.kind = KIND_REJECT;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_count <= '0;
    end else begin
      phase <= phase_next;
      if (in_accept) begin
        if (file_start) begin
          header_count <= HDR_CNT_W'(1);
        end else if (phase == PH_HEADER) begin
          header_count <= HDR_CNT_W'(header_count + 1'b1);
        end
      end
    end
  end

  // Row size in bytes and bottom-row offset follow the header fields.
  always_ff @(posedge clk) begin
    row_bytes <= W3W'(img_w) + W3W'({img_w, 1'b0});
    base_prod <= OFF_W'(prod_full);
  end

  // Header fields, counters and pixel data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (file_start) begin
        width_field     <= '0;
        height_field    <= '0;
        bit_count_field <= '0;
      end else if (phase == PH_HEADER) begin
        if (header_count >= HDR_CNT_W'(HDR_WIDTH_POS) &&
            header_count < HDR_CNT_W'(HDR_WIDTH_POS + 4)) begin
          width_field[{lane_w, 3'b000} +: BYTE_W] <= byte_value;
        end
        if (header_count >= HDR_CNT_W'(HDR_HEIGHT_POS) &&
            header_count < HDR_CNT_W'(HDR_HEIGHT_POS + 4)) begin
          height_field[{lane_h, 3'b000} +: BYTE_W] <= byte_value;
        end
        if (header_count >= HDR_CNT_W'(HDR_BPP_POS) &&
            header_count < HDR_CNT_W'(HDR_BPP_POS + 2)) begin
          bit_count_field[{lane_b[0], 3'b000} +: BYTE_W] <= byte_value;
        end
        if (hdr_end) begin
          row_count     <= '0;
          column_count  <= '0;
          byte_in_pixel <= '0;
          row_base      <= base_prod;
          pixel_offset  <= base_prod;
        end
      end else if (phase == PH_PIXELS) begin
        if (byte_in_pixel == 2'd0) begin
          held_first    <= byte_value;
          byte_in_pixel <= 2'd1;
        end else if (byte_in_pixel == 2'd1) begin
          held_second   <= byte_value;
          byte_in_pixel <= 2'd2;
        end else begin
          byte_in_pixel <= 2'd0;
          column_count  <= CW'(column_count + 1'b1);
          pixel_offset  <= pixel_offset + OFF_W'(PIX_BYTES);
        end
        if (go_pad) begin
          pad_count <= pad;
        end
      end else if (phase == PH_PAD) begin
        pad_count <= 2'(pad_count - 1'b1);
      end
      // Start of the next row overrides the column step above.
      if (row_done) begin
        row_count    <= RW'(row_count + 1'b1);
        column_count <= '0;
        row_base     <= next_base;
        pixel_offset <= next_base;
      end
    end
  end

  // A pad run always has bytes left to skip.
  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> (pad_count != 2'd0))
    else $error("pad phase with no pad bytes left");

  // Pixel counters stay inside the image.
  a_pix_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (column_count < img_w && row_count < img_h &&
                              byte_in_pixel != 2'd3))
    else $error("pixel counters outside the image");

  // The last pixel of an image ends the pixel stream.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.last) |=> (phase != PH_PIXELS && phase != PH_PAD))
    else $error("pixel stream continues after the last pixel");

endmodule

`default_nettype wire

// ===== src/bsl_queue.sv =====
// Short result queue between the parser and the output stage.
`default_nettype none

module bsl_queue
  import bsl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  input  wire logic    pop,
  output logic         not_empty,
  output result_t      pop_data
);

  result_t              entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= Q_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= Q_PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= Q_CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= Q_CNT_W'(count - 1'b1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level above its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result pushed into a full queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    Q_PTR_W'(wr_ptr - rd_ptr) == count[Q_PTR_W-1:0])
    else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

// ===== src/bsl_back.sv =====
// Output stage: holds one result until the receiver takes it.
`default_nettype none

module bsl_back
  import bsl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_not_empty,
  input  wire result_t q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  // Refill whenever the register is empty or being emptied.
  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= q_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/bmp24_stream_loader_unit.sv =====
// Top level of the 24-bit BMP stream loader.
//
// The slave stream takes one file byte per item in s_tdata, with s_tuser high on
// the first byte of a file. The 54-byte header is checked for 24 bits per pixel
// and for the width and height held in the two configuration registers. A bad
// header gives one reject item (m_tuser high, data zero); a good one gives one
// pixel write per three pixel bytes, at the byte offset of the flipped row, with
// m_tlast on the final pixel. Row pad bytes and trailing bytes give no item.
// One byte is taken every clock cycle while s_tready is high. A result is written
// into the queue when the byte completing it is accepted, and moves on into the
// output register when that is empty or being emptied; a four-entry queue and the
// output register sit between parser and receiver, so s_tready falls only when
// the receiver has stalled long enough to fill them.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready; the
// user is to write it only while the block is idle; the block does not enforce it.
// Reset clears the parser to wait for a file start, empties the queue and sets
// both dimension registers to 32.
`default_nettype none

module bmp24_stream_loader_unit
  import bsl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input byte stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] byte_value
  input  wire logic                  s_tuser,   // [0] file_start
  // Result stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [21:0] byte_offset, [29:22] first_byte,
                                                // [37:30] second_byte, [45:38] third_byte
  output logic                       m_tuser,   // [0] kind
  output logic                       m_tlast,
  // Configuration writes.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  cfg_t    cfg;
  logic    in_accept;
  logic    push;
  result_t push_data;
  logic    q_full;
  logic    q_pop;
  logic    q_not_empty;
  result_t q_data;
  result_t out_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign in_accept = s_tvalid && s_tready;

  // Dimension registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_width  <= CFG_W'(32);
      cfg.expected_height <= CFG_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXPECTED_WIDTH:  cfg.expected_width  <= cfg_data;
        REG_EXPECTED_HEIGHT: cfg.expected_height <= cfg_data;
      endcase
    end
  end

  bsl_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .byte_value (s_tdata),
    .file_start (s_tuser),
    .cfg        (cfg),
    .push       (push),
    .push_data  (push_data)
  );

  bsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  bsl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (out_data)
  );

  // Pack the result item onto the master side.
  assign m_tdata = {2'b00, out_data.third_byte, out_data.second_byte,
                    out_data.first_byte, out_data.byte_offset};
  assign m_tuser = out_data.kind;
  assign m_tlast = out_data.last;

endmodule

`default_nettype wire
